// File: hw/rtl/ssi_pkg.sv
// Shared widths, pipeline stage map, types and register indexes for the segment intersector.
package ssi_pkg;

   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;
   localparam int VEC_W   = COORD_W + 1;
   localparam int PROD_W  = 2 * COORD_W;
   localparam int DEN_W   = PROD_W + 1;
   localparam int ADEN_W  = PROD_W;
   localparam int ANUM_W  = VEC_W + COORD_W;
   localparam int NUM_W   = ANUM_W + 1;
   localparam int TQ_W    = FRAC_W + 2;
   localparam int T_W     = TQ_W + 1;
   localparam int PT_W    = COORD_W + T_W;
   localparam int SUM_W   = PT_W + 1;
   localparam int THR_W   = 32;
   localparam int TOL_W   = 16;
   localparam int CSR_W   = 32;

   localparam int ST_VEC  = 0;
   localparam int ST_MUL  = 1;
   localparam int ST_SUB  = 2;
   localparam int ST_CHK  = 3;
   localparam int ST_DIV0 = 4;
   localparam int ST_RNG  = ST_DIV0 + TQ_W;
   localparam int ST_PMUL = ST_RNG + 1;
   localparam int ST_OUT  = ST_PMUL + 1;
   localparam int NSTG    = ST_OUT + 1;

   typedef enum logic [0:0] {
      CSR_PAR_THRESH = 1'b0,
      CSR_PARAM_TOL  = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic signed [COORD_W-1:0] dx;
      logic signed [COORD_W-1:0] dy;
   } seg_type;

   typedef struct packed {
      logic [ADEN_W-1:0] rem;
      logic [TQ_W-1:0]   nb;
      logic [TQ_W-1:0]   q;
   } div_type;

endpackage

// File: hw/rtl/ssi_req_if.sv
// Request and response channel interfaces of the segment intersector.
interface ssi_req_if;
   import ssi_pkg::*;
   logic valid;
   logic ready;
   logic signed [COORD_W-1:0] a_start_x;
   logic signed [COORD_W-1:0] a_start_y;
   logic signed [COORD_W-1:0] a_dir_x;
   logic signed [COORD_W-1:0] a_dir_y;
   logic signed [COORD_W-1:0] b_start_x;
   logic signed [COORD_W-1:0] b_start_y;
   logic signed [COORD_W-1:0] b_dir_x;
   logic signed [COORD_W-1:0] b_dir_y;
   modport source (output valid, a_start_x, a_start_y, a_dir_x, a_dir_y,
                   b_start_x, b_start_y, b_dir_x, b_dir_y, input ready);
   modport sink (input valid, a_start_x, a_start_y, a_dir_x, a_dir_y,
                 b_start_x, b_start_y, b_dir_x, b_dir_y, output ready);
endinterface

interface ssi_rsp_if;
   import ssi_pkg::*;
   logic valid;
   logic ready;
   logic hit;
   logic signed [COORD_W-1:0] hit_x;
   logic signed [COORD_W-1:0] hit_y;
   modport source (output valid, hit, hit_x, hit_y, input ready);
   modport sink (input valid, hit, hit_x, hit_y, output ready);
endinterface

// File: hw/rtl/segment_segment_intersection_2d.sv
// Segment intersector: one pair of segments per cycle, while the output is not stalled,
// through a 25-stage pipeline, returning one item per pair (ready permitting). Stages:
// difference vector, six exact cross-product multiplies, subtract, magnitude and range
// pre-checks, then an 18-stage restoring divider (one quotient bit per stage, both
// parameters in parallel), the parameter range test, the point multiply and the final
// shift, add and saturation. Each stage has its own valid bit, so bubbles collapse and
// a stalled output holds only what is behind it. The divider (FRAC_W + 2 stages) makes
// up most of the pipeline. Registers: index 0 is the parallel threshold, index 1 the
// parameter tolerance; write them while idle.
module segment_segment_intersection_2d (
   input  logic                        clock,
   input  logic                        reset,
   ssi_req_if.sink                     req_ch,
   ssi_rsp_if.source                   rsp_ch,
   input  logic                        csr_wr_en,
   input  ssi_pkg::csr_idx_type        csr_index,
   input  logic [ssi_pkg::CSR_W-1:0]   csr_wdata
);
   import ssi_pkg::*;

   function automatic div_type div_step(input div_type x, input logic [ADEN_W-1:0] den);
      logic [ADEN_W:0] s;
      div_type y;
      s = {x.rem, x.nb[TQ_W-1]};
      y.nb = {x.nb[TQ_W-2:0], 1'b0};
      if (s >= {1'b0, den}) begin
         y.rem = ADEN_W'(s - {1'b0, den});
         y.q = {x.q[TQ_W-2:0], 1'b1};
      end else begin
         y.rem = ADEN_W'(s);
         y.q = {x.q[TQ_W-2:0], 1'b0};
      end
      return y;
   endfunction

   logic [THR_W-1:0] thresh_ff;
   logic [TOL_W-1:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THR_W'(1);
         tol_ff <= TOL_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PAR_THRESH: thresh_ff <= csr_wdata[THR_W-1:0];
            CSR_PARAM_TOL: tol_ff <= csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // flow control: a stage loads when it is empty or its successor loads
   logic [NSTG-1:0] vld_ff, vld_in, adv;

   always_comb begin
      adv[NSTG-1] = !vld_ff[NSTG-1] || rsp_ch.ready;
      for (int k = NSTG - 2; k >= 0; k--) adv[k] = !vld_ff[k] || adv[k+1];
      vld_in[0] = req_ch.valid;
      for (int k = 1; k < NSTG; k++) vld_in[k] = vld_ff[k-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) if (adv[k]) vld_ff[k] <= vld_in[k];
      end
   end

   assign req_ch.ready = adv[ST_VEC];

   // difference vector
   seg_type seg0_ff;
   logic signed [VEC_W-1:0] vx_ff, vy_ff;
   logic signed [COORD_W-1:0] bdx_ff, bdy_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_VEC]) begin
         seg0_ff <= '{sx: req_ch.a_start_x, sy: req_ch.a_start_y,
                      dx: req_ch.a_dir_x, dy: req_ch.a_dir_y};
         vx_ff <= VEC_W'(req_ch.b_start_x) - VEC_W'(req_ch.a_start_x);
         vy_ff <= VEC_W'(req_ch.b_start_y) - VEC_W'(req_ch.a_start_y);
         bdx_ff <= req_ch.b_dir_x;
         bdy_ff <= req_ch.b_dir_y;
      end
   end

   // exact cross-product terms
   seg_type seg1_ff;
   logic signed [PROD_W-1:0] p_adby_ff, p_aybx_ff;
   logic signed [ANUM_W-1:0] p_vxby_ff, p_vybx_ff, p_vxay_ff, p_vyax_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_MUL]) begin
         seg1_ff <= seg0_ff;
         p_adby_ff <= PROD_W'(seg0_ff.dx) * PROD_W'(bdy_ff);
         p_aybx_ff <= PROD_W'(seg0_ff.dy) * PROD_W'(bdx_ff);
         p_vxby_ff <= ANUM_W'(vx_ff) * ANUM_W'(bdy_ff);
         p_vybx_ff <= ANUM_W'(vy_ff) * ANUM_W'(bdx_ff);
         p_vxay_ff <= ANUM_W'(vx_ff) * ANUM_W'(seg0_ff.dy);
         p_vyax_ff <= ANUM_W'(vy_ff) * ANUM_W'(seg0_ff.dx);
      end
   end

   seg_type seg2_ff;
   logic signed [DEN_W-1:0] d_ff;
   logic signed [NUM_W-1:0] n1_ff, n2_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_SUB]) begin
         seg2_ff <= seg1_ff;
         d_ff <= DEN_W'(p_adby_ff) - DEN_W'(p_aybx_ff);
         n2_ff <= NUM_W'(p_vxby_ff) - NUM_W'(p_vybx_ff);
         n1_ff <= NUM_W'(p_vxay_ff) - NUM_W'(p_vyax_ff);
      end
   end

   // magnitudes, parallel test and quotient overflow test
   logic [ADEN_W-1:0] ad_c;
   logic [ANUM_W-1:0] an1_c, an2_c;
   logic par_c, ovf1_c, ovf2_c;
   div_type dv1_c, dv2_c;

   always_comb begin
      ad_c = d_ff[DEN_W-1] ? ADEN_W'(-d_ff) : ADEN_W'(d_ff);
      an2_c = n2_ff[NUM_W-1] ? ANUM_W'(-n2_ff) : ANUM_W'(n2_ff);
      an1_c = n1_ff[NUM_W-1] ? ANUM_W'(-n1_ff) : ANUM_W'(n1_ff);
      par_c = (ad_c == '0) || (ad_c < ADEN_W'(thresh_ff));
      // the quotient needs more than TQ_W bits: far outside the segment
      ovf2_c = {1'b0, an2_c} >= {ad_c, 2'b00};
      ovf1_c = {1'b0, an1_c} >= {ad_c, 2'b00};
      dv1_c.rem = ADEN_W'(an2_c >> 2);
      dv1_c.nb = {an2_c[1:0], FRAC_W'(0)};
      dv1_c.q = '0;
      dv2_c.rem = ADEN_W'(an1_c >> 2);
      dv2_c.nb = {an1_c[1:0], FRAC_W'(0)};
      dv2_c.q = '0;
   end

   seg_type seg3_ff;
   logic [ADEN_W-1:0] ad3_ff;
   div_type dv1_3_ff, dv2_3_ff;
   logic neg1_3_ff, neg2_3_ff, miss3_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_CHK]) begin
         seg3_ff <= seg2_ff;
         ad3_ff <= ad_c;
         dv1_3_ff <= dv1_c;
         dv2_3_ff <= dv2_c;
         neg1_3_ff <= n2_ff[NUM_W-1] ^ d_ff[DEN_W-1];
         neg2_3_ff <= n1_ff[NUM_W-1] ^ d_ff[DEN_W-1];
         miss3_ff <= par_c || ovf1_c || ovf2_c;
      end
   end

   // divider: one quotient bit per stage for both parameters
   seg_type seg_d_ff [TQ_W];
   logic [ADEN_W-1:0] ad_d_ff [TQ_W];
   div_type dv1_d_ff [TQ_W];
   div_type dv2_d_ff [TQ_W];
   logic [TQ_W-1:0] neg1_d_ff, neg2_d_ff, miss_d_ff;

   for (genvar j = 0; j < TQ_W; j++) begin : g_div
      seg_type src_seg;
      logic [ADEN_W-1:0] src_ad;
      div_type src_dv1, src_dv2;
      logic src_neg1, src_neg2, src_miss;

      if (j == 0) begin : g_first
         assign src_seg = seg3_ff;
         assign src_ad = ad3_ff;
         assign src_dv1 = dv1_3_ff;
         assign src_dv2 = dv2_3_ff;
         assign src_neg1 = neg1_3_ff;
         assign src_neg2 = neg2_3_ff;
         assign src_miss = miss3_ff;
      end else begin : g_next
         assign src_seg = seg_d_ff[j-1];
         assign src_ad = ad_d_ff[j-1];
         assign src_dv1 = dv1_d_ff[j-1];
         assign src_dv2 = dv2_d_ff[j-1];
         assign src_neg1 = neg1_d_ff[j-1];
         assign src_neg2 = neg2_d_ff[j-1];
         assign src_miss = miss_d_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (adv[ST_DIV0+j]) begin
            seg_d_ff[j] <= src_seg;
            ad_d_ff[j] <= src_ad;
            dv1_d_ff[j] <= div_step(src_dv1, src_ad);
            dv2_d_ff[j] <= div_step(src_dv2, src_ad);
            neg1_d_ff[j] <= src_neg1;
            neg2_d_ff[j] <= src_neg2;
            miss_d_ff[j] <= src_miss;
         end
      end
   end

   // parameter range test
   logic [TQ_W-1:0] q1_c, q2_c, tol_c, lim_c;
   logic bad1_c, bad2_c;
   logic signed [T_W-1:0] tq_c;

   always_comb begin
      q1_c = dv1_d_ff[TQ_W-1].q;
      q2_c = dv2_d_ff[TQ_W-1].q;
      tol_c = TQ_W'(tol_ff);
      lim_c = (TQ_W'(1) << FRAC_W) + tol_c;
      bad1_c = neg1_d_ff[TQ_W-1] ? (q1_c > tol_c) : (q1_c > lim_c);
      bad2_c = neg2_d_ff[TQ_W-1] ? (q2_c > tol_c) : (q2_c > lim_c);
      tq_c = $signed({1'b0, q1_c});
   end

   seg_type seg_r_ff;
   logic hit_r_ff;
   logic signed [T_W-1:0] t1_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_RNG]) begin
         seg_r_ff <= seg_d_ff[TQ_W-1];
         hit_r_ff <= !miss_d_ff[TQ_W-1] && !bad1_c && !bad2_c;
         t1_ff <= neg1_d_ff[TQ_W-1] ? -tq_c : tq_c;
      end
   end

   // point: start + dir * t1
   logic signed [PT_W-1:0] px_ff, py_ff;
   logic signed [COORD_W-1:0] sx_p_ff, sy_p_ff;
   logic hit_p_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_PMUL]) begin
         px_ff <= PT_W'(seg_r_ff.dx) * PT_W'(t1_ff);
         py_ff <= PT_W'(seg_r_ff.dy) * PT_W'(t1_ff);
         sx_p_ff <= seg_r_ff.sx;
         sy_p_ff <= seg_r_ff.sy;
         hit_p_ff <= hit_r_ff;
      end
   end

   localparam logic [COORD_W-1:0] MAX_C = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] MIN_C = {1'b1, {(COORD_W-1){1'b0}}};

   logic signed [PT_W-1:0] shx_c, shy_c;
   logic signed [SUM_W-1:0] sumx_c, sumy_c;
   logic [COORD_W-1:0] hx_c, hy_c;

   always_comb begin
      shx_c = px_ff >>> FRAC_W;
      shy_c = py_ff >>> FRAC_W;
      sumx_c = SUM_W'(shx_c) + SUM_W'(sx_p_ff);
      sumy_c = SUM_W'(shy_c) + SUM_W'(sy_p_ff);
      if ((sumx_c[SUM_W-1:COORD_W-1] == '0) || (sumx_c[SUM_W-1:COORD_W-1] == '1)) begin
         hx_c = sumx_c[COORD_W-1:0];
      end else begin
         hx_c = sumx_c[SUM_W-1] ? MIN_C : MAX_C;
      end
      if ((sumy_c[SUM_W-1:COORD_W-1] == '0) || (sumy_c[SUM_W-1:COORD_W-1] == '1)) begin
         hy_c = sumy_c[COORD_W-1:0];
      end else begin
         hy_c = sumy_c[SUM_W-1] ? MIN_C : MAX_C;
      end
      // drop the point on a miss
      if (!hit_p_ff) begin
         hx_c = '0;
         hy_c = '0;
      end
   end

   logic hit_o_ff;
   logic [COORD_W-1:0] hx_o_ff, hy_o_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         hit_o_ff <= hit_p_ff;
         hx_o_ff <= hx_c;
         hy_o_ff <= hy_c;
      end
   end

   assign rsp_ch.valid = vld_ff[ST_OUT];
   assign rsp_ch.hit = hit_o_ff;
   assign rsp_ch.hit_x = $signed(hx_o_ff);
   assign rsp_ch.hit_y = $signed(hy_o_ff);

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.hit |-> rsp_ch.hit_x == '0 && rsp_ch.hit_y == '0)
      else $error("miss item carries a nonzero point");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_RNG-1] && !miss_d_ff[TQ_W-1] |->
         dv1_d_ff[TQ_W-1].rem < ad_d_ff[TQ_W-1] && dv2_d_ff[TQ_W-1].rem < ad_d_ff[TQ_W-1])
      else $error("divider remainder not below divisor");

   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> vld_ff[ST_VEC])
      else $error("accepted item not loaded into first stage");

endmodule
